// ===== design/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg
// Types and constants shared by the sorted deadline timer queue modules.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int TIME_W        = 32;
  localparam int TASK_W        = 5;
  localparam int MASK_W        = 32;
  localparam int PCOUNT_W      = 6;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_DISPATCH = 1'b1
  } sdtq_op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_IDLE     = 2'd2,
    ST_FIRED    = 2'd3
  } sdtq_status_t;

  typedef struct packed {
    logic                op;
    logic [TIME_W-1:0]   now_ms;
    logic [TIME_W-1:0]   delay_ms;
    logic [TASK_W-1:0]   task_id;
  } sdtq_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TASK_W-1:0]   fired_task;
    logic [MASK_W-1:0]   event_mask;
    logic [PCOUNT_W-1:0] pending_count;
  } sdtq_out_t;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [TASK_W-1:0]   task_id;
  } sdtq_entry_t;

  typedef struct packed {
    logic                ins;
    logic                pop;
    sdtq_entry_t         fresh;
  } sdtq_ctl_t;

endpackage

// ===== design/sdtq_cell.sv =====
// ----------------------------------------------------------------------------
// sdtq_cell
// One slot of the sorted queue: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module sdtq_cell import sdtq_pkg::*; (
  input  logic        clk,
  input  sdtq_ctl_t   ctl,
  input  logic        held,
  input  logic        left_keep,
  input  sdtq_entry_t left_entry,
  input  sdtq_entry_t right_entry,
  output logic        keep,
  output sdtq_entry_t entry
);

  assign keep = held && (entry.deadline <= ctl.fresh.deadline);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!keep) begin
        entry <= left_keep ? ctl.fresh : left_entry;
      end
    end else if (ctl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== design/sorted_deadline_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_core
// Sorted timer queue of DEPTH deadlines built as a row of shifting cells.
// ----------------------------------------------------------------------------
// For each transaction, busy is high for the cycle after start is
// taken, while the registered command (with its deadline sum) drives every
// cell at once; the cells compare in parallel and shift in that same cycle,
// and the result appears with done on the next cycle. A new transaction may be
// started in the cycle done is high. Results are held until the next transaction;
// take them while done is high. Entry contents need no reset.
module sorted_deadline_timer_queue_core import sdtq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sdtq_in_t  cmd,
  output logic      done,
  output sdtq_out_t result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic              cmd_valid;
  logic              cmd_op;
  logic [TIME_W-1:0] cmd_now;
  sdtq_entry_t       cmd_entry;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  sdtq_out_t         result_next;
  sdtq_ctl_t         ctl;
  logic              full;
  logic              due;

  logic              keep_v  [DEPTH];
  sdtq_entry_t       entry_v [DEPTH];

  assign busy = cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_op             <= cmd.op;
      cmd_now            <= cmd.now_ms;
      cmd_entry.deadline <= cmd.now_ms + cmd.delay_ms;
      cmd_entry.task_id  <= cmd.task_id;
    end
  end

  assign full = (count == CW'(DEPTH));
  assign due  = (count != '0) && (entry_v[0].deadline <= cmd_now);

  always_comb begin
    ctl.ins   = cmd_valid && (cmd_op == OP_INSERT) && !full;
    ctl.pop   = cmd_valid && (cmd_op == OP_DISPATCH) && due;
    ctl.fresh = cmd_entry;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic        lkeep;
    sdtq_entry_t lentry;
    sdtq_entry_t rentry;
    if (i == 0) begin : g_first
      assign lkeep  = 1'b1;
      assign lentry = cmd_entry;
    end else begin : g_mid
      assign lkeep  = keep_v[i-1];
      assign lentry = entry_v[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rentry = entry_v[i];
    end else begin : g_inner
      assign rentry = entry_v[i+1];
    end
    sdtq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .held        (count > CW'(i)),
      .left_keep   (lkeep),
      .left_entry  (lentry),
      .right_entry (rentry),
      .keep        (keep_v[i]),
      .entry       (entry_v[i])
    );
  end

  always_comb begin
    count_next  = count;
    result_next = '0;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
    if (cmd_op == OP_INSERT) begin
      result_next.status = full ? ST_DROPPED : ST_INSERTED;
    end else if (due) begin
      result_next.status     = ST_FIRED;
      result_next.fired_task = entry_v[0].task_id;
      result_next.event_mask = MASK_W'(1) << entry_v[0].task_id;
    end else begin
      result_next.status = ST_IDLE;
    end
    result_next.pending_count = PCOUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      result <= result_next;
    end
  end

  a_busy_then_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("transaction did not complete");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_fired_mask: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FIRED |-> $onehot(result.event_mask))
    else $error("fired event mask not one-hot");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(count))
    else $error("entry count changed without a transaction");

endmodule
